FILE: rtl/utf8v_pkg.sv
// utf8v_pkg: shared types and constants for the utf-8 stream validator
// no dependencies
`timescale 1ns / 1ps

package utf8v_pkg;

  // allowed range of the next continuation byte
  typedef enum logic [2:0] {
    RANGE_80_BF = 3'd0,
    RANGE_A0_BF = 3'd1,
    RANGE_80_9F = 3'd2,
    RANGE_90_BF = 3'd3,
    RANGE_80_8F = 3'd4
  } range_class_t;

  // decoded lead byte
  typedef struct packed {
    logic         is_ascii;
    logic         is_bad;
    logic [1:0]   cont_count;
    range_class_t first_range;
  } lead_info_t;

  localparam logic [7:0] CONT_LO     = 8'h80;
  localparam logic [7:0] CONT_HI     = 8'hbf;
  localparam logic [7:0] LEAD2_MIN   = 8'hc2;
  localparam logic [7:0] LEAD3_MIN   = 8'he0;
  localparam logic [7:0] LEAD3_SURR  = 8'hed;
  localparam logic [7:0] LEAD4_MIN   = 8'hf0;
  localparam logic [7:0] LEAD4_MAX   = 8'hf4;

endpackage

FILE: rtl/utf8v_classify.sv
// utf8v_classify: lead byte decode and continuation range check
// depends on utf8v_pkg
`timescale 1ns / 1ps

module utf8v_classify import utf8v_pkg::*; (
  input  logic [7:0]   data_byte,
  input  range_class_t range_class,
  output lead_info_t   lead,
  output logic         cont_ok
);

  logic [7:0] lo;
  logic [7:0] hi;

  always_comb begin
    lead = '{is_ascii: 1'b0, is_bad: 1'b0, cont_count: 2'd0, first_range: RANGE_80_BF};
    priority if (data_byte < CONT_LO) begin
      lead.is_ascii = 1'b1;
    end else if (data_byte < LEAD2_MIN) begin
      lead.is_bad = 1'b1;
    end else if (data_byte < LEAD3_MIN) begin
      lead.cont_count = 2'd1;
    end else if (data_byte == LEAD3_MIN) begin
      lead.cont_count  = 2'd2;
      lead.first_range = RANGE_A0_BF;
    end else if (data_byte == LEAD3_SURR) begin
      lead.cont_count  = 2'd2;
      lead.first_range = RANGE_80_9F;
    end else if (data_byte < LEAD4_MIN) begin
      lead.cont_count = 2'd2;
    end else if (data_byte == LEAD4_MIN) begin
      lead.cont_count  = 2'd3;
      lead.first_range = RANGE_90_BF;
    end else if (data_byte < LEAD4_MAX) begin
      lead.cont_count = 2'd3;
    end else if (data_byte == LEAD4_MAX) begin
      lead.cont_count  = 2'd3;
      lead.first_range = RANGE_80_8F;
    end else begin
      lead.is_bad = 1'b1;
    end
  end

  always_comb begin
    unique case (range_class)
      RANGE_A0_BF: begin
        lo = 8'ha0;
        hi = CONT_HI;
      end
      RANGE_80_9F: begin
        lo = CONT_LO;
        hi = 8'h9f;
      end
      RANGE_90_BF: begin
        lo = 8'h90;
        hi = CONT_HI;
      end
      RANGE_80_8F: begin
        lo = CONT_LO;
        hi = 8'h8f;
      end
      default: begin
        lo = CONT_LO;
        hi = CONT_HI;
      end
    endcase
    cont_ok = (data_byte >= lo) && (data_byte <= hi);
  end

endmodule

FILE: rtl/utf8_stream_validator.sv
// utf8_stream_validator: checks byte strings for well-formed utf-8, one verdict per string
// depends on utf8v_pkg and utf8v_classify
// the verdict is registered and appears in the cycle after the last byte of a string is accepted
// throughput: one byte per cycle; stalls only while a verdict waits and out_ready is low
// reset: synchronous active-high rst clears sequence state and out_valid; string_valid is not reset
`timescale 1ns / 1ps

module utf8_stream_validator import utf8v_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       string_valid
);

  logic [1:0]   expected;
  logic [1:0]   expected_next;
  range_class_t range_class;
  range_class_t range_class_next;
  logic         error_seen;
  logic         error_seen_next;
  logic         in_fire;
  logic         verdict;
  lead_info_t   lead;
  logic         cont_ok;

  utf8v_classify u_classify (
    .data_byte   (data_byte),
    .range_class (range_class),
    .lead        (lead),
    .cont_ok     (cont_ok)
  );

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    expected_next    = expected;
    range_class_next = range_class;
    error_seen_next  = error_seen;
    if (!error_seen) begin
      if (expected == 2'd0) begin
        if (lead.is_bad) begin
          error_seen_next = 1'b1;
        end else if (!lead.is_ascii) begin
          expected_next    = lead.cont_count;
          range_class_next = lead.first_range;
        end
      end else begin
        if (!cont_ok) begin
          error_seen_next = 1'b1;
        end else begin
          expected_next    = expected - 2'd1;
          range_class_next = RANGE_80_BF;
        end
      end
    end
    verdict = !error_seen_next && (expected_next == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected    <= 2'd0;
      range_class <= RANGE_80_BF;
      error_seen  <= 1'b0;
    end else if (in_fire) begin
      if (end_of_string) begin
        expected    <= 2'd0;
        range_class <= RANGE_80_BF;
        error_seen  <= 1'b0;
      end else begin
        expected    <= expected_next;
        range_class <= range_class_next;
        error_seen  <= error_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && end_of_string) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && end_of_string) begin
      string_valid <= verdict;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_string |=> expected == 2'd0 && !error_seen && range_class == RANGE_80_BF)
    else $error("sequence state not cleared after last item");

  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_string |=> out_valid)
    else $error("no verdict after last item");

  a_range_needs_owed: assert property (@(posedge clk) disable iff (rst)
    range_class != RANGE_80_BF |-> expected != 2'd0)
    else $error("narrow range class with no continuation owed");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending verdict");
`endif

endmodule
